// ===== rtl/core/imgrot_pkg.sv =====
`default_nettype none

package imgrot_pkg;

   // Width of one stored BGR pixel.
   localparam int PIXEL_BITS = 24;

   // Width of the configuration register index and data.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 9;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIRECTION    = 2'd2;

   // Request action codes.
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_EMIT  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic wr_en;       // store the request pixel and advance the write count
      logic emit_start;  // latch the source position of the next output pixel
      logic addr_en;     // form the linear store address
      logic read_en;     // read the frame store
      logic out_load;    // move the read pixel into the response register
   } imgrot_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_full;  // the whole frame has been written
   } imgrot_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/imgrot_datapath.sv =====
`default_nettype none

module imgrot_datapath
   import imgrot_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire imgrot_cmd_type                      cmd,
   output imgrot_status_type                        status,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      img_w,
   input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]     img_h,
   input  wire logic                                direction,
   input  wire logic [7:0]                          req_blue_in,
   input  wire logic [7:0]                          req_green_in,
   input  wire logic [7:0]                          req_red_in,
   output logic [7:0]                               rsp_blue_out,
   output logic [7:0]                               rsp_green_out,
   output logic [7:0]                               rsp_red_out,
   output logic                                     rsp_last_pixel
);

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int RW    = $clog2(MAX_WIDTH);
   localparam int CW    = $clog2(MAX_HEIGHT);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   // Frame store, contents undefined until written.
   logic [PIXEL_BITS-1:0] mem [DEPTH];

   logic [NW-1:0]         write_count_ff, write_count_in;
   logic [NW-1:0]         total_ff;
   logic [RW-1:0]         out_row_ff, out_row_in;
   logic [CW-1:0]         out_col_ff, out_col_in;
   logic [CW-1:0]         src_r_ff;
   logic [RW-1:0]         src_c_ff;
   logic                  last_ff;
   logic [AW-1:0]         addr_ff;
   logic [PIXEL_BITS-1:0] rdata_ff;

   logic                  restart;
   logic [RW-1:0]         row_eff;
   logic [CW-1:0]         col_eff;
   logic [CW-1:0]         src_r;
   logic [RW-1:0]         src_c;
   logic                  last;

   // Frame size, recomputed every cycle from the configuration.
   always_ff @(posedge clock) begin
      total_ff <= NW'(img_w) * NW'(img_h);
   end

   assign status.frame_full = (write_count_ff >= total_ff);

   // Write side: raster order into the store, ignored once the frame is full.
   assign write_count_in = cmd.wr_en ? write_count_ff + NW'(1) : write_count_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[write_count_ff[AW-1:0]] <= {req_red_in, req_green_in, req_blue_in};
      end
   end

   // Output position, restarted when the size shrank below it.
   always_comb begin
      restart = (32'(out_row_ff) >= 32'(img_w)) || (32'(out_col_ff) >= 32'(img_h));
      row_eff = restart ? '0 : out_row_ff;
      col_eff = restart ? '0 : out_col_ff;

      if (direction) begin
         src_r = CW'(img_h - HW'(1) - HW'(col_eff));
         src_c = row_eff;
      end else begin
         src_r = col_eff;
         src_c = RW'(img_w - WW'(1) - WW'(row_eff));
      end

      last = (WW'(row_eff) == img_w - WW'(1)) && (HW'(col_eff) == img_h - HW'(1));

      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (cmd.emit_start) begin
         if (32'(col_eff) + 1 >= 32'(img_h)) begin
            out_col_in = '0;
            if (32'(row_eff) + 1 >= 32'(img_w)) begin
               out_row_in = '0;
            end else begin
               out_row_in = row_eff + RW'(1);
            end
         end else begin
            out_col_in = col_eff + CW'(1);
            out_row_in = row_eff;
         end
      end
   end

   // Counters and position.
   always_ff @(posedge clock) begin
      if (reset) begin
         write_count_ff <= '0;
         out_row_ff     <= '0;
         out_col_ff     <= '0;
      end else begin
         write_count_ff <= write_count_in;
         out_row_ff     <= out_row_in;
         out_col_ff     <= out_col_in;
      end
   end

   // Emit pipeline: source position, linear address, store read, response.
   always_ff @(posedge clock) begin
      if (cmd.emit_start) begin
         src_r_ff <= src_r;
         src_c_ff <= src_c;
         last_ff  <= last;
      end
      if (cmd.addr_en) begin
         addr_ff <= AW'(NW'(src_r_ff) * NW'(img_w) + NW'(src_c_ff));
      end
      if (cmd.read_en) begin
         rdata_ff <= mem[addr_ff];
      end
      if (cmd.out_load) begin
         rsp_red_out    <= rdata_ff[23:16];
         rsp_green_out  <= rdata_ff[15:8];
         rsp_blue_out   <= rdata_ff[7:0];
         rsp_last_pixel <= last_ff;
      end
   end

   // A write command always advances the count by exactly one.
   a_write_advances: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |=> write_count_ff == $past(write_count_ff) + NW'(1))
      else $error("write count did not advance on a stored pixel");

   // The write count never moves without a write command.
   a_count_holds: assert property (@(posedge clock) disable iff (reset)
      !cmd.wr_en |=> write_count_ff == $past(write_count_ff))
      else $error("write count moved without a write");

   // The latched source row stays inside the frame height.
   a_src_row_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_start |=> 32'(src_r_ff) < 32'(img_h))
      else $error("source row outside the frame");

endmodule

`default_nettype wire

// ===== rtl/core/imgrot_ctrl.sv =====
`default_nettype none

module imgrot_ctrl
   import imgrot_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_action,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic               csr_write_en,
   input  wire imgrot_status_type  status,
   output imgrot_cmd_type          cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       settle_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_accept;
   logic       out_free;

   // Requests stall during reset or a register write and for the cycle after it, so the frame size settles.
   assign req_stall  = reset || csr_write_en || settle_ff || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_action == ACTION_EMIT) begin
                  cmd.emit_start = 1'b1;
                  state_in       = ST_CALC;
               end else begin
                  cmd.wr_en = !status.frame_full;
               end
            end
         end
         ST_CALC: begin
            cmd.addr_en = 1'b1;
            state_in    = ST_READ;
         end
         ST_READ: begin
            cmd.read_en = 1'b1;
            state_in    = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid holds until the response is taken.
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         settle_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         settle_ff    <= csr_write_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted emit request starts the address stage next cycle.
   a_emit_to_calc: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_action == ACTION_EMIT) |=> state_ff == ST_CALC)
      else $error("emit request did not start the pipeline");

   // A response is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response register overwritten");

   // Every load shows up as a valid response next cycle.
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded response not presented");

endmodule

`default_nettype wire

// ===== rtl/core/image_rotate_90.sv =====
// Quarter-turn frame rotation with a single-port frame store.
// Write requests may follow back to back, except while a register write stalls them.
// An emit request passes in order through source position, address multiply, store read
// and response register; the next request is not accepted until the response is loaded,
// and the load waits while an earlier response is still stalled.
// Reset clears counters and control and sets width 256, height 256, direction 0.
// The frame store is not cleared; each pixel is undefined until written.
`default_nettype none

module image_rotate_90
   import imgrot_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_action,
   input  wire logic [7:0]                req_blue_in,
   input  wire logic [7:0]                req_green_in,
   input  wire logic [7:0]                req_red_in,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [7:0]                     rsp_blue_out,
   output logic [7:0]                     rsp_green_out,
   output logic [7:0]                     rsp_red_out,
   output logic                           rsp_last_pixel,
   input  wire logic                      csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [CSR_DATA_BITS-1:0] image_width_ff;
   logic [CSR_DATA_BITS-1:0] image_height_ff;
   logic                     direction_ff;
   logic [WW-1:0]            img_w;
   logic [HW-1:0]            img_h;
   imgrot_cmd_type           cmd;
   imgrot_status_type        status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= CSR_DATA_BITS'(256);
         image_height_ff <= CSR_DATA_BITS'(256);
         direction_ff    <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_data;
            CSR_DIRECTION:    direction_ff    <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Clamp the sizes to one through the store dimensions.
   always_comb begin
      if (image_width_ff == '0) begin
         img_w = WW'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         img_w = WW'(MAX_WIDTH);
      end else begin
         img_w = WW'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         img_h = HW'(1);
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         img_h = HW'(MAX_HEIGHT);
      end else begin
         img_h = HW'(image_height_ff);
      end
   end

   imgrot_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_action   (req_action),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .csr_write_en (csr_write_en),
      .status       (status),
      .cmd          (cmd)
   );

   imgrot_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .img_w          (img_w),
      .img_h          (img_h),
      .direction      (direction_ff),
      .req_blue_in    (req_blue_in),
      .req_green_in   (req_green_in),
      .req_red_in     (req_red_in),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_red_out    (rsp_red_out),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule

`default_nettype wire
